/* rtl/core/fsms_pkg.sv */
`timescale 1ns / 1ps
package fsms_pkg;

  localparam int unsigned QUERY_MAX   = 32;
  localparam int unsigned ENTRY_MAX   = 255;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned QLEN_W  = 6;
  localparam int unsigned GAP_W   = 9;
  localparam int unsigned SCORE_W = 10;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned NUM_WORDS = 4;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [4:0] FIRST_BONUS = 5'd16;
  localparam logic [4:0] WORD_BONUS  = 5'd8;
  localparam logic [4:0] DOT_BONUS   = 5'd4;

  localparam logic [7:0] CHR_UNDERSCORE = 8'h5f;
  localparam logic [7:0] CHR_DASH       = 8'h2d;
  localparam logic [7:0] CHR_SPACE      = 8'h20;
  localparam logic [7:0] CHR_DOT        = 8'h2e;
  localparam logic [7:0] CHR_UP_A       = 8'h41;
  localparam logic [7:0] CHR_UP_Z       = 8'h5a;
  localparam logic [7:0] CHR_LOW_A      = 8'h61;
  localparam logic [7:0] CHR_LOW_Z      = 8'h7a;
  localparam logic [7:0] CASE_OFFSET    = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_LENGTH  = 3'd0,
    REG_QUERY_BYTES_0 = 3'd1,
    REG_QUERY_BYTES_1 = 3'd2,
    REG_QUERY_BYTES_2 = 3'd3,
    REG_QUERY_BYTES_3 = 3'd4
  } cfg_reg_t;

  // classified candidate byte as it travels from front to back
  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] folded;
    logic       is_up;
    logic       is_low;
    logic       is_sep;
    logic       is_dot;
    logic       has;
    logic       last;
  } item_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= CHR_UP_A) && (c <= CHR_UP_Z);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= CHR_LOW_A) && (c <= CHR_LOW_Z);
  endfunction

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    return is_upper(c) ? c + CASE_OFFSET : c;
  endfunction

endpackage

/* rtl/core/fsms_intf.sv */
`timescale 1ns / 1ps
interface fsms_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] entry_byte;
  logic       carries_byte;
  logic       entry_end;
  modport source (output valid, entry_byte, carries_byte, entry_end, input ready);
  modport sink   (input valid, entry_byte, carries_byte, entry_end, output ready);
endinterface

interface fsms_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fsms_pkg::SCORE_W-1:0] match_score;
  logic                                query_consumed;
  modport source (output valid, match_score, query_consumed, input ready);
  modport sink   (input valid, match_score, query_consumed, output ready);
endinterface

interface fsms_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fsms_pkg::CFG_IDX_W-1:0] reg_index;
  logic [fsms_pkg::WORD_W-1:0]    write_data;
  modport source (output valid, reg_index, write_data, input ready);
  modport sink   (input valid, reg_index, write_data, output ready);
endinterface

/* rtl/core/fsms_front.sv */
`timescale 1ns / 1ps
module fsms_front (
  fsms_in_if.sink         in_chan,
  input  logic            q_full,
  output logic            push,
  output fsms_pkg::item_t push_item
);

  logic [7:0] c;

  assign c             = in_chan.entry_byte;
  assign in_chan.ready = !q_full;
  assign push          = in_chan.valid && !q_full;

  always_comb begin
    push_item.raw    = c;
    push_item.folded = fsms_pkg::fold_byte(c);
    push_item.is_up  = fsms_pkg::is_upper(c);
    push_item.is_low = fsms_pkg::is_lower(c);
    push_item.is_sep = (c == fsms_pkg::CHR_UNDERSCORE) || (c == fsms_pkg::CHR_DASH) ||
                       (c == fsms_pkg::CHR_SPACE);
    push_item.is_dot = (c == fsms_pkg::CHR_DOT);
    push_item.has    = in_chan.carries_byte;
    push_item.last   = in_chan.entry_end;
  end

endmodule

/* rtl/core/fsms_queue.sv */
`timescale 1ns / 1ps
module fsms_queue #(
  parameter int unsigned DEPTH = fsms_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fsms_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output fsms_pkg::item_t head_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  fsms_pkg::item_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

endmodule

/* rtl/core/fsms_back.sv */
`timescale 1ns / 1ps
module fsms_back (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             head_valid,
  input  fsms_pkg::item_t                                  head_item,
  output logic                                             pop,
  input  logic [fsms_pkg::QLEN_W-1:0]                      eff_len,
  input  logic [fsms_pkg::NUM_WORDS*fsms_pkg::WORD_W-1:0]  query_bits,
  fsms_out_if.source                                       out_chan
);

  localparam int unsigned QLEN_W  = fsms_pkg::QLEN_W;
  localparam int unsigned GAP_W   = fsms_pkg::GAP_W;
  localparam int unsigned SCORE_W = fsms_pkg::SCORE_W;
  localparam logic [GAP_W-1:0] GAP_LIMIT = GAP_W'(fsms_pkg::ENTRY_MAX);

  logic [QLEN_W-1:0]  qpos_r, qpos_nxt;
  logic [1:0]         epos_r, epos_nxt;
  logic               prev_low_r, prev_low_nxt;
  logic               prev_sep_r, prev_sep_nxt;
  logic               prev_dot_r, prev_dot_nxt;
  logic               prev_match_r, prev_match_nxt;
  logic [SCORE_W-1:0] bonus_r, bonus_nxt;
  logic [GAP_W-1:0]   gap_r, gap_nxt;
  logic               out_valid_r;
  logic [SCORE_W-1:0] out_score_r;
  logic               out_consumed_r;

  logic [7:0]  q_byte;
  logic        active;
  logic        hit;
  logic [4:0]  add;
  logic [SCORE_W-1:0] final_score;
  logic        final_consumed;

  assign q_byte = query_bits[{qpos_r[4:0], 3'b000} +: 8];
  assign active = head_item.has && (qpos_r < eff_len);
  assign hit    = (fsms_pkg::fold_byte(q_byte) == head_item.folded);

  // a result may only leave the queue when the output register can take it
  assign pop = head_valid && (!head_item.last || !out_valid_r || out_chan.ready);

  always_comb begin
    add = 5'd1;
    if (q_byte == head_item.raw) begin
      add = add + 5'd1;
    end
    if ((epos_r == 2'd0) && (qpos_r == '0)) begin
      add = add + fsms_pkg::FIRST_BONUS;
    end else begin
      if ((head_item.is_up && prev_low_r) || prev_sep_r) begin
        add = add + fsms_pkg::WORD_BONUS;
      end
      // epos saturates at two, so equality means position two or later
      if ((epos_r == 2'd2) && prev_dot_r) begin
        add = add + fsms_pkg::DOT_BONUS;
      end
    end
    if (prev_match_r) begin
      add = add + 5'd1;
    end
  end

  always_comb begin
    qpos_nxt       = qpos_r;
    epos_nxt       = epos_r;
    prev_low_nxt   = prev_low_r;
    prev_sep_nxt   = prev_sep_r;
    prev_dot_nxt   = prev_dot_r;
    prev_match_nxt = prev_match_r;
    bonus_nxt      = bonus_r;
    gap_nxt        = gap_r;
    if (pop && active) begin
      if (hit) begin
        bonus_nxt      = bonus_r + SCORE_W'(add);
        qpos_nxt       = qpos_r + 1'b1;
        prev_match_nxt = 1'b1;
      end else begin
        if (gap_r < GAP_LIMIT) begin
          gap_nxt = gap_r + 1'b1;
        end
        prev_match_nxt = 1'b0;
      end
      prev_low_nxt = head_item.is_low;
      prev_sep_nxt = head_item.is_sep;
      prev_dot_nxt = head_item.is_dot;
      if (epos_r != 2'd2) begin
        epos_nxt = epos_r + 1'b1;
      end
    end
    final_score    = bonus_nxt - SCORE_W'(gap_nxt);
    final_consumed = (qpos_nxt >= eff_len);
    if (pop && head_item.last) begin
      qpos_nxt       = '0;
      epos_nxt       = '0;
      prev_low_nxt   = 1'b0;
      prev_sep_nxt   = 1'b0;
      prev_dot_nxt   = 1'b0;
      prev_match_nxt = 1'b0;
      bonus_nxt      = '0;
      gap_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qpos_r       <= '0;
      epos_r       <= '0;
      prev_low_r   <= 1'b0;
      prev_sep_r   <= 1'b0;
      prev_dot_r   <= 1'b0;
      prev_match_r <= 1'b0;
      bonus_r      <= '0;
      gap_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      qpos_r       <= qpos_nxt;
      epos_r       <= epos_nxt;
      prev_low_r   <= prev_low_nxt;
      prev_sep_r   <= prev_sep_nxt;
      prev_dot_r   <= prev_dot_nxt;
      prev_match_r <= prev_match_nxt;
      bonus_r      <= bonus_nxt;
      gap_r        <= gap_nxt;
      if (pop && head_item.last) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_item.last) begin
      out_score_r    <= final_score;
      out_consumed_r <= final_consumed;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.match_score    = $signed(out_score_r);
  assign out_chan.query_consumed = out_consumed_r;

endmodule

/* rtl/core/fuzzy_subsequence_match_scorer_core.sv */
`timescale 1ns / 1ps
// a candidate's final item goes through the item queue, then is scored into the output
// register, which raises out valid; it waits in the queue while an older result is held
// throughput: one item per cycle, set by the scoring update in the back end
// the input side keeps taking items while a result waits, until the item queue is full
// reset (synchronous, rst_n low) empties the queue, clears scoring state and output valid,
// and returns the query registers to zero
module fuzzy_subsequence_match_scorer_core #(
  parameter int unsigned QUEUE_DEPTH = fsms_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  fsms_in_if.sink     in_chan,
  fsms_out_if.source  out_chan,
  fsms_cfg_if.sink    cfg_chan
);

  localparam int unsigned QLEN_W = fsms_pkg::QLEN_W;
  localparam int unsigned WORD_W = fsms_pkg::WORD_W;

  logic [QLEN_W-1:0]                        qlen_r;
  logic [fsms_pkg::NUM_WORDS-1:0][WORD_W-1:0] qword_r;
  logic [QLEN_W-1:0]                        eff_len;

  logic            push;
  fsms_pkg::item_t push_item;
  logic            q_full;
  logic            pop;
  logic            head_valid;
  fsms_pkg::item_t head_item;

  assign cfg_chan.ready = 1'b1;
  assign eff_len = (qlen_r > QLEN_W'(fsms_pkg::QUERY_MAX)) ?
                   QLEN_W'(fsms_pkg::QUERY_MAX) : qlen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r  <= '0;
      qword_r <= '0;
    end else if (cfg_chan.valid) begin
      unique case (fsms_pkg::cfg_reg_t'(cfg_chan.reg_index))
        fsms_pkg::REG_QUERY_LENGTH:  qlen_r     <= cfg_chan.write_data[QLEN_W-1:0];
        fsms_pkg::REG_QUERY_BYTES_0: qword_r[0] <= cfg_chan.write_data;
        fsms_pkg::REG_QUERY_BYTES_1: qword_r[1] <= cfg_chan.write_data;
        fsms_pkg::REG_QUERY_BYTES_2: qword_r[2] <= cfg_chan.write_data;
        fsms_pkg::REG_QUERY_BYTES_3: qword_r[3] <= cfg_chan.write_data;
        default: begin
          // writes to unused indexes are dropped
        end
      endcase
    end
  end

  fsms_front u_front (
    .in_chan   (in_chan),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  fsms_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  fsms_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .eff_len    (eff_len),
    .query_bits (qword_r),
    .out_chan   (out_chan)
  );

endmodule

/* tb/tb_fuzzy_subsequence_match_scorer_core.sv */
`timescale 1ns / 1ps
module tb_fuzzy_subsequence_match_scorer_core;

  localparam int CLK_HALF    = 5;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 10;
  localparam int LONG_PHASE  = 3;
  localparam int HOLD_PHASE  = 4;
  localparam int LONG_TEXT   = 260;
  localparam int MAX_PRINTS  = 40;

  typedef struct {
    logic signed [fsms_pkg::SCORE_W-1:0] score;
    logic                                consumed;
  } score_result_t;

  typedef enum int {RX_STEADY, RX_RANDOM, RX_PATTERN} rx_mode_t;

  class score_tracker;
    logic [fsms_pkg::QLEN_W-1:0]  query_len;
    logic [fsms_pkg::WORD_W-1:0]  query_word [fsms_pkg::NUM_WORDS];
    logic [fsms_pkg::QLEN_W-1:0]  qpos;
    logic [1:0]                   epos;
    logic [7:0]                   prev_byte;
    logic                         prev_hit;
    logic [fsms_pkg::SCORE_W-1:0] bonus;
    logic [fsms_pkg::GAP_W-1:0]   gaps;
    score_result_t                expected_scores [$];
    int                           mismatches;
    int                           items_seen;
    int                           results_seen;
    int                           full_matches;
    int                           reg_writes;

    function new();
      query_len = '0;
      foreach (query_word[i]) query_word[i] = '0;
      mismatches = 0;
      items_seen = 0;
      results_seen = 0;
      full_matches = 0;
      reg_writes = 0;
      restart_candidate();
    endfunction

    function void restart_candidate();
      qpos = '0;
      epos = '0;
      prev_byte = '0;
      prev_hit = 1'b0;
      bonus = '0;
      gaps = '0;
    endfunction

    function bit is_cap(logic [7:0] c);
      return c inside {[8'h41:8'h5a]};
    endfunction

    function bit is_small(logic [7:0] c);
      return c inside {[8'h61:8'h7a]};
    endfunction

    function logic [7:0] as_lower(logic [7:0] c);
      return is_cap(c) ? (c | 8'h20) : c;
    endfunction

    function logic [fsms_pkg::QLEN_W-1:0] active_length();
      return (query_len > fsms_pkg::QUERY_MAX) ?
             fsms_pkg::QLEN_W'(fsms_pkg::QUERY_MAX) : query_len;
    endfunction

    function void write_reg(fsms_pkg::cfg_reg_t idx, logic [fsms_pkg::WORD_W-1:0] data);
      reg_writes++;
      case (idx)
        fsms_pkg::REG_QUERY_LENGTH:  query_len = data[fsms_pkg::QLEN_W-1:0];
        fsms_pkg::REG_QUERY_BYTES_0: query_word[0] = data;
        fsms_pkg::REG_QUERY_BYTES_1: query_word[1] = data;
        fsms_pkg::REG_QUERY_BYTES_2: query_word[2] = data;
        fsms_pkg::REG_QUERY_BYTES_3: query_word[3] = data;
        default: ;
      endcase
    endfunction

    function void score_candidate_byte(logic [7:0] c);
      logic [4:0]                   slot;
      logic [7:0]                   q;
      logic [fsms_pkg::SCORE_W-1:0] add;
      slot = qpos[4:0];
      q = query_word[slot[4:3]][slot[2:0]*8 +: 8];
      if (as_lower(q) == as_lower(c)) begin
        add = fsms_pkg::SCORE_W'(1);
        if (q == c) add = add + 1'b1;
        if (epos == 0 && qpos == 0) begin
          add = add + fsms_pkg::FIRST_BONUS;
        end else begin
          if ((is_cap(c) && is_small(prev_byte)) || prev_byte == fsms_pkg::CHR_UNDERSCORE ||
              prev_byte == fsms_pkg::CHR_DASH || prev_byte == fsms_pkg::CHR_SPACE)
            add = add + fsms_pkg::WORD_BONUS;
          if (epos >= 2 && prev_byte == fsms_pkg::CHR_DOT) add = add + fsms_pkg::DOT_BONUS;
        end
        if (prev_hit) add = add + 1'b1;
        bonus = bonus + add;
        qpos = qpos + 1'b1;
        prev_hit = 1'b1;
      end else begin
        if (gaps < fsms_pkg::ENTRY_MAX) gaps = gaps + 1'b1;
        prev_hit = 1'b0;
      end
      prev_byte = c;
      if (epos < 2) epos = epos + 1'b1;
    endfunction

    function void note_item(logic [7:0] c, logic has, logic last);
      score_result_t res;
      items_seen++;
      if (has && qpos < active_length()) score_candidate_byte(c);
      if (last) begin
        res.score = bonus - {1'b0, gaps};
        res.consumed = (qpos >= active_length());
        expected_scores.insert(expected_scores.size(), res);
        restart_candidate();
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_score(logic signed [fsms_pkg::SCORE_W-1:0] score, logic consumed);
      score_result_t res;
      if (expected_scores.size() == 0) begin
        report_mismatch($sformatf("unexpected result score=%0d consumed=%0b", score, consumed));
        return;
      end
      res = expected_scores.pop_front();
      results_seen++;
      if (score !== res.score)
        report_mismatch($sformatf("result %0d: score %0d, expected %0d",
                                  results_seen, score, res.score));
      if (consumed !== res.consumed)
        report_mismatch($sformatf("result %0d: consumed %0b, expected %0b",
                                  results_seen, consumed, res.consumed));
      if (res.consumed) full_matches++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  fsms_in_if  in_if();
  fsms_out_if out_if();
  fsms_cfg_if cfg_if();

  fuzzy_subsequence_match_scorer_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  score_tracker sb = new();

  logic [7:0] query_text [fsms_pkg::QUERY_MAX];
  int         cur_len;
  int         burst_left = 0;
  bit         sender_steady = 1'b0;
  bit         hold_off_req = 1'b0;
  int         idle_cycles = 0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // all transfers are noted here, config and input before results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready)
        sb.write_reg(fsms_pkg::cfg_reg_t'(cfg_if.reg_index), cfg_if.write_data);
      if (in_if.valid && in_if.ready)
        sb.note_item(in_if.entry_byte, in_if.carries_byte, in_if.entry_end);
      if (out_if.valid && out_if.ready)
        sb.check_score(out_if.match_score, out_if.query_consumed);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stall modes, plus a long hold-off on request
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       hold;
    int       tick;
    mode = RX_STEADY;
    mode_left = 0;
    hold = 0;
    tick = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_if.ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        case (mode)
          RX_STEADY:  out_if.ready = 1'b1;
          RX_RANDOM:  out_if.ready = 1'($urandom_range(0, 1));
          RX_PATTERN: out_if.ready = (tick % 5) < 3;
          default:    out_if.ready = 1'b1;
        endcase
      end
    end
  end

  task automatic send_item(input logic [7:0] c, input logic has, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (sender_steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        @(negedge clk);
        in_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_if.valid = 1'b1;
    in_if.entry_byte = c;
    in_if.carries_byte = has;
    in_if.entry_end = last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    burst_left--;
  endtask

  // stop sending, let every score come back and the item queue drain
  task automatic wait_quiet();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (sb.expected_scores.size() != 0) @(posedge clk);
    repeat (fsms_pkg::QUEUE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_reg(input fsms_pkg::cfg_reg_t idx,
                           input logic [fsms_pkg::WORD_W-1:0] data);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.reg_index = idx;
    cfg_if.write_data = data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic load_query(input int len);
    logic [fsms_pkg::WORD_W-1:0] word;
    write_reg(fsms_pkg::REG_QUERY_LENGTH, fsms_pkg::WORD_W'(len));
    for (int w = 0; w < fsms_pkg::NUM_WORDS; w++) begin
      for (int k = 0; k < 8; k++) word[k*8 +: 8] = query_text[w*8 + k];
      write_reg(fsms_pkg::cfg_reg_t'(fsms_pkg::REG_QUERY_BYTES_0 + w), word);
    end
    @(negedge clk);
    cfg_if.valid = 1'b0;
    cur_len = (len > fsms_pkg::QUERY_MAX) ? fsms_pkg::QUERY_MAX : len;
  endtask

  function automatic logic [7:0] pick_letter();
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] pick_noise();
    case ($urandom_range(0, 5))
      0: case ($urandom_range(0, 3))
           0: return fsms_pkg::CHR_UNDERSCORE;
           1: return fsms_pkg::CHR_DASH;
           2: return fsms_pkg::CHR_SPACE;
           default: return fsms_pkg::CHR_DOT;
         endcase
      1, 2: return pick_letter();
      3: return 8'($urandom);
      4: return 8'h30 + 8'($urandom_range(0, 9));
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  task automatic send_text(input logic [7:0] text [$]);
    bit end_on_empty;
    end_on_empty = ($urandom_range(0, 7) == 0);
    if (text.size() == 0) begin
      send_item(8'($urandom), 1'b0, 1'b1);
      return;
    end
    foreach (text[i]) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(text[i], 1'b1, (i == text.size() - 1) && !end_on_empty);
    end
    if (end_on_empty) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // mostly candidates that walk the query in order, with noise between bytes
  task automatic send_random_candidate();
    logic [7:0] text [$];
    logic [7:0] q;
    int         kind;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      for (int i = 0; i < cur_len; i++) begin
        if ($urandom_range(0, 9) == 0) continue;
        repeat ($urandom_range(0, 2)) text.insert(text.size(), pick_noise());
        q = query_text[i];
        if (sb.is_cap(q) || sb.is_small(q)) begin
          if ($urandom_range(0, 2) == 0) q = q ^ 8'h20;
        end
        text.insert(text.size(), q);
      end
      repeat ($urandom_range(0, 2)) text.insert(text.size(), pick_noise());
    end else if (kind <= 8) begin
      repeat ($urandom_range(1, 10)) text.insert(text.size(), pick_noise());
    end
    send_text(text);
  endtask

  task automatic configure_phase(input int p);
    int len;
    case (p)
      0: begin
        len = fsms_pkg::QUERY_MAX;
        foreach (query_text[i]) query_text[i] = 8'hff;
      end
      1: begin
        len = 63;
        foreach (query_text[i]) query_text[i] = pick_letter();
      end
      2: begin
        len = 0;
        foreach (query_text[i]) query_text[i] = 8'h00;
      end
      LONG_PHASE: begin
        len = 3;
        foreach (query_text[i]) query_text[i] = 8'h61 + 8'($urandom_range(0, 25));
      end
      default: begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        foreach (query_text[i])
          query_text[i] = ($urandom_range(0, 9) < 6) ? pick_letter() : pick_noise();
      end
    endcase
    sender_steady = (p == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
    load_query(len);
  endtask

  initial begin : stimulus
    logic [7:0] long_text [$];
    int         phase_start;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.entry_byte = '0;
    in_if.carries_byte = 1'b0;
    in_if.entry_end = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.reg_index = fsms_pkg::REG_QUERY_LENGTH;
    cfg_if.write_data = '0;
    foreach (query_text[i]) query_text[i] = 8'h00;
    cur_len = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // empty query after reset, then an empty candidate
    send_item("Z", 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);

    // query "abc" plus 0xff, first with an oversized length
    wait_quiet();
    query_text[0] = "a";
    query_text[1] = "b";
    query_text[2] = "c";
    query_text[3] = 8'hff;
    load_query(63);
    send_item("A", 1'b1, 1'b1);
    wait_quiet();
    write_reg(fsms_pkg::REG_QUERY_LENGTH, fsms_pkg::WORD_W'(4));
    @(negedge clk);
    cfg_if.valid = 1'b0;
    cur_len = 4;

    // first byte, separator word start, dot bonus, consecutive, ignored tail
    send_item("A", 1'b1, 1'b0);
    send_item(fsms_pkg::CHR_UNDERSCORE, 1'b1, 1'b0);
    send_item("B", 1'b1, 1'b0);
    send_item(fsms_pkg::CHR_DOT, 1'b1, 1'b0);
    send_item("c", 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    // camel case, end on an item without a byte
    send_item("x", 1'b1, 1'b0);
    send_item("a", 1'b1, 1'b0);
    send_item("B", 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    // dash and space starts
    send_item(fsms_pkg::CHR_DASH, 1'b1, 1'b0);
    send_item("a", 1'b1, 1'b0);
    send_item(fsms_pkg::CHR_SPACE, 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    // shorten the query while a candidate is open
    send_item("a", 1'b1, 1'b0);
    wait_quiet();
    write_reg(fsms_pkg::REG_QUERY_LENGTH, fsms_pkg::WORD_W'(1));
    @(negedge clk);
    cfg_if.valid = 1'b0;
    cur_len = 1;
    send_item("z", 1'b1, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      wait_quiet();
      if (p == HOLD_PHASE) hold_off_req = 1'b1;
      configure_phase(p);
      if (p == LONG_PHASE) begin
        long_text.delete();
        repeat (LONG_TEXT) long_text.insert(long_text.size(), 8'($urandom_range(128, 255)));
        for (int i = 0; i < cur_len; i++) long_text.insert(long_text.size(), query_text[i]);
        send_text(long_text);
      end
      phase_start = sb.items_seen;
      while (sb.items_seen - phase_start < PHASE_ITEMS) send_random_candidate();
    end

    @(negedge clk);
    in_if.valid = 1'b0;
    while (sb.expected_scores.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d items and %0d scores, %0d with the whole query matched",
             sb.items_seen, sb.results_seen, sb.full_matches);
    $display("over %0d register writes across %0d query settings", sb.reg_writes, PHASES + 2);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
